[src/dfda_pkg.sv]
// Package: shared types, codes and helpers of the deferred-free descriptor allocator.
`timescale 1ns / 1ps

package dfda_pkg;

  // Widths fixed by the item fields
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned SLOT_OUT_W = 10;
  localparam int unsigned CAP_W      = 11;
  localparam int unsigned STRIDE_W   = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  // Internal command fields sized for the largest parameter values
  localparam int unsigned CMD_IDX_W   = 16;
  localparam int unsigned CMD_FRAME_W = 3;

  localparam int unsigned DEF_MAX_SLOTS = 1024;
  localparam int unsigned DEF_FRAMES    = 3;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_PROCESS = 2'd2,
    OP_BAD     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY       = 3'd0,
    REG_SLOT_STRIDE    = 3'd1,
    REG_CPU_BASE       = 3'd2,
    REG_GPU_BASE       = 3'd3,
    REG_SHADER_VISIBLE = 3'd4
  } reg_index_t;

  // What the back end has to do with a classified item
  typedef enum logic [1:0] {
    K_ALLOC  = 2'd0,
    K_FREE   = 2'd1,
    K_PROC   = 2'd2,
    K_REJECT = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] handle_address;
    logic [1:0]        frame_slot;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [ADDR_W-1:0]     cpu_address;
    logic [ADDR_W-1:0]     gpu_address;
  } rsp_t;

  typedef struct packed {
    logic [CAP_W-1:0]    capacity;
    logic [STRIDE_W-1:0] slot_stride;
    logic [ADDR_W-1:0]   cpu_base;
    logic [ADDR_W-1:0]   gpu_base;
    logic                shader_visible;
  } cfg_t;

  typedef struct packed {
    kind_t                  kind;
    status_t                status;
    logic [CMD_IDX_W-1:0]   idx;
    logic [CMD_FRAME_W-1:0] frame;
  } cmd_t;

  // A zero stride behaves as a stride of one
  function automatic logic [STRIDE_W-1:0] eff_stride(input logic [STRIDE_W-1:0] s);
    return (s == '0) ? STRIDE_W'(1) : s;
  endfunction

endpackage

[src/deferred_free_descriptor_allocator.sv]
// Top level of the deferred-free descriptor allocator: register file and part wiring.
//
//  Channel   Signals                       Handshake
//  request   req_valid, req_stall, req     transfer when req_valid && !req_stall
//  response  rsp_valid, rsp_stall, rsp     transfer when rsp_valid && !rsp_stall
//  config    cfg_valid, cfg_ready,         write when cfg_valid && cfg_ready
//            cfg_index, cfg_data
//
// Allocate runs through the queue hop with stack read, the stride multiply and the base add.
// A free waits on the 4-bit-per-cycle divider and then on the push, both holding the front,
// so no next request is taken until the free has been pushed.
// Process reads the queue and writes the stack for each parked index in turn;
// a rejected request or a full heap is answered as it leaves the queue.
// After reset the stack is filled with its identity; no request is taken meanwhile.
// A stalled response holds in its register while the front keeps going.
`timescale 1ns / 1ps

module deferred_free_descriptor_allocator #(
  parameter int unsigned MAX_SLOTS = dfda_pkg::DEF_MAX_SLOTS,
  parameter int unsigned FRAMES    = dfda_pkg::DEF_FRAMES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  dfda_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output dfda_pkg::rsp_t                     rsp,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dfda_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dfda_pkg::ADDR_W-1:0]        cfg_data
);
  import dfda_pkg::*;

  cfg_t cfg;
  cmd_t push_data;
  cmd_t head;
  logic push;
  logic full;
  logic pop;
  logic empty;
  logic busy;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity       <= CAP_W'(1024);
      cfg.slot_stride    <= STRIDE_W'(32);
      cfg.cpu_base       <= '0;
      cfg.gpu_base       <= '0;
      cfg.shader_visible <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_CAPACITY:       cfg.capacity       <= cfg_data[CAP_W-1:0];
        REG_SLOT_STRIDE:    cfg.slot_stride    <= cfg_data[STRIDE_W-1:0];
        REG_CPU_BASE:       cfg.cpu_base       <= cfg_data;
        REG_GPU_BASE:       cfg.gpu_base       <= cfg_data;
        REG_SHADER_VISIBLE: cfg.shader_visible <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dfda_front #(.MAX_SLOTS(MAX_SLOTS), .FRAMES(FRAMES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg       (cfg),
    .busy      (busy),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  dfda_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  dfda_back #(.MAX_SLOTS(MAX_SLOTS), .FRAMES(FRAMES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

[src/dfda_fifo.sv]
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps

module dfda_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dfda_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output dfda_pkg::cmd_t pop_data,
  output logic          empty
);
  import dfda_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  // Storage needs no reset
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/dfda_front.sv]
// Front end: accepts requests, checks them and turns free addresses into slot indices.
`timescale 1ns / 1ps

module dfda_front #(
  parameter int unsigned MAX_SLOTS = dfda_pkg::DEF_MAX_SLOTS,
  parameter int unsigned FRAMES    = dfda_pkg::DEF_FRAMES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dfda_pkg::req_t req,
  input  dfda_pkg::cfg_t cfg,
  input  logic           busy,
  output logic           push,
  output dfda_pkg::cmd_t push_data,
  input  logic           full
);
  import dfda_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_SLOTS + 1);
  localparam int unsigned STEPS = 4;                 // quotient bits per cycle
  localparam int unsigned ITERS = ADDR_W / STEPS;
  localparam int unsigned IT_W  = $clog2(ITERS);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t             state;
  logic [ADDR_W-1:0]   dq;      // dividend shifting out, quotient shifting in
  logic [STRIDE_W-1:0] rem;
  logic [IT_W-1:0]     iter;
  logic [CMD_FRAME_W-1:0] frame_r;

  logic [STRIDE_W-1:0] stride;
  logic [CW-1:0]       cap_eff;
  logic [ADDR_W-1:0]   diff;
  logic                frame_bad;
  logic                accept;
  logic [ADDR_W-1:0]   dq_next;
  logic [STRIDE_W-1:0] rem_next;
  cmd_t                cmd_now;

  assign stride    = eff_stride(cfg.slot_stride);
  assign cap_eff   = (32'(cfg.capacity) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(cfg.capacity);
  assign diff      = req.handle_address - cfg.cpu_base;
  assign frame_bad = ({2'b00, req.frame_slot} >= 4'(FRAMES));
  assign req_stall = (state != F_IDLE) || full || busy;
  assign accept    = req_valid && !req_stall;

  // Four restoring division steps on the narrow remainder
  always_comb begin
    logic [STRIDE_W:0]   r2;
    logic [ADDR_W-1:0]   d;
    logic [STRIDE_W-1:0] r;
    d = dq;
    r = rem;
    for (int k = 0; k < STEPS; k++) begin
      r2 = {r, d[ADDR_W-1]};
      if (r2 >= {1'b0, stride}) begin
        r2 = r2 - {1'b0, stride};
        d  = {d[ADDR_W-2:0], 1'b1};
      end else begin
        d  = {d[ADDR_W-2:0], 1'b0};
      end
      r = r2[STRIDE_W-1:0];
    end
    dq_next  = d;
    rem_next = r;
  end

  // Classification of an item that needs no division
  always_comb begin
    cmd_now        = '0;
    cmd_now.frame  = CMD_FRAME_W'(req.frame_slot);
    cmd_now.status = ST_OK;
    unique case (opcode_t'(req.opcode))
      OP_ALLOC: cmd_now.kind = K_ALLOC;
      OP_PROCESS: begin
        cmd_now.kind = frame_bad ? K_REJECT : K_PROC;
        if (frame_bad) begin
          cmd_now.status = ST_RANGE;
        end
      end
      OP_FREE: begin
        cmd_now.kind = K_REJECT;
        if (req.handle_address == '0) begin
          cmd_now.status = ST_INVALID;
        end else begin
          cmd_now.status = ST_RANGE;
        end
      end
      default: begin
        cmd_now.kind   = K_REJECT;
        cmd_now.status = ST_RANGE;
      end
    endcase
  end

  // Push: immediate for plain items, after the divider for a free
  always_comb begin
    push      = 1'b0;
    push_data = cmd_now;
    if (state == F_PUSH) begin
      push            = 1'b1;
      push_data       = '0;
      push_data.frame = frame_r;
      if (rem != '0 || dq >= ADDR_W'(cap_eff)) begin
        push_data.kind   = K_REJECT;
        push_data.status = ST_RANGE;
      end else begin
        push_data.kind   = K_FREE;
        push_data.status = ST_OK;
        push_data.idx    = CMD_IDX_W'(dq);
      end
    end else if (accept) begin
      push = !(req.opcode == OP_FREE && req.handle_address != '0 && !frame_bad
               && req.handle_address >= cfg.cpu_base);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept && req.opcode == OP_FREE && req.handle_address != '0 && !frame_bad
              && req.handle_address >= cfg.cpu_base) begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (iter == IT_W'(ITERS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      dq      <= diff;
      rem     <= '0;
      iter    <= '0;
      frame_r <= CMD_FRAME_W'(req.frame_slot);
    end else if (state == F_DIV) begin
      dq   <= dq_next;
      rem  <= rem_next;
      iter <= iter + IT_W'(1);
    end
  end

endmodule

[src/dfda_back.sv]
// Back end: slot stack, deferred queues, address generation and the result register.
`timescale 1ns / 1ps

module dfda_back #(
  parameter int unsigned MAX_SLOTS = dfda_pkg::DEF_MAX_SLOTS,
  parameter int unsigned FRAMES    = dfda_pkg::DEF_FRAMES
) (
  input  logic           clk,
  input  logic           rst,
  input  dfda_pkg::cfg_t cfg,
  input  dfda_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  output logic           busy,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dfda_pkg::rsp_t rsp
);
  import dfda_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_SLOTS);
  localparam int unsigned CW    = $clog2(MAX_SLOTS + 1);
  localparam int unsigned FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned OFF_W = IW + STRIDE_W;

  typedef enum logic [5:0] {
    B_CLEAR     = 6'b000001,
    B_IDLE      = 6'b000010,
    B_ALLOC_RD  = 6'b000100,
    B_ALLOC_ADD = 6'b001000,
    B_PROC_RD   = 6'b010000,
    B_PROC_WR   = 6'b100000
  } bstate_t;

  bstate_t        state;
  logic [IW-1:0]  stack [MAX_SLOTS];
  logic [IW-1:0]  dqueue [FRAMES][MAX_SLOTS];
  logic [IW-1:0]  st_rdata;
  logic [IW-1:0]  q_rdata;
  logic [CW-1:0]  used_count;
  logic [CW-1:0]  dcount [FRAMES];
  logic [IW-1:0]  clr_cnt;
  logic [CW-1:0]  pi;
  logic [FW-1:0]  cur_frame;
  logic [IW-1:0]  idx_r;
  logic [OFF_W-1:0] off;

  logic [CW-1:0]  cap_eff;
  logic [FW-1:0]  head_frame;
  logic           res_free;
  logic           st_we;
  logic [IW-1:0]  st_waddr;
  logic [IW-1:0]  st_wdata;
  logic           q_we;

  assign cap_eff    = (32'(cfg.capacity) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(cfg.capacity);
  assign head_frame = FW'(head.frame);
  assign res_free   = !rsp_valid || !rsp_stall;
  assign pop        = (state == B_IDLE) && !empty && res_free;
  assign busy       = (state == B_CLEAR);

  // Stack write port: identity fill after reset, refill while draining
  always_comb begin
    st_we    = 1'b0;
    st_waddr = clr_cnt;
    st_wdata = clr_cnt;
    if (state == B_CLEAR) begin
      st_we = 1'b1;
    end else if (state == B_PROC_WR && used_count != '0) begin
      st_we    = 1'b1;
      st_waddr = IW'(used_count - CW'(1));
      st_wdata = q_rdata;
    end
  end

  assign q_we = pop && head.kind == K_FREE && dcount[head_frame] < CW'(MAX_SLOTS);

  always_ff @(posedge clk) begin
    if (st_we) begin
      stack[st_waddr] <= st_wdata;
    end
    st_rdata <= stack[used_count[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      dqueue[head_frame][dcount[head_frame][IW-1:0]] <= IW'(head.idx);
    end
    q_rdata <= dqueue[cur_frame][pi[IW-1:0]];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      clr_cnt    <= '0;
      used_count <= '0;
      rsp_valid  <= 1'b0;
      for (int f = 0; f < FRAMES; f++) begin
        dcount[f] <= '0;
      end
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          clr_cnt <= clr_cnt + IW'(1);
          if (clr_cnt == IW'(MAX_SLOTS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop) begin
            unique case (head.kind)
              K_ALLOC: begin
                if (used_count >= cap_eff) begin
                  rsp_valid <= 1'b1;
                end else begin
                  used_count <= used_count + CW'(1);
                  state      <= B_ALLOC_RD;
                end
              end
              K_FREE: begin
                rsp_valid <= 1'b1;
                if (q_we) begin
                  dcount[head_frame] <= dcount[head_frame] + CW'(1);
                end
              end
              K_PROC: begin
                if (dcount[head_frame] == '0) begin
                  rsp_valid <= 1'b1;
                end else begin
                  state <= B_PROC_RD;
                end
              end
              default: rsp_valid <= 1'b1;
            endcase
          end
        end
        B_ALLOC_RD:  state <= B_ALLOC_ADD;
        B_ALLOC_ADD: begin
          rsp_valid <= 1'b1;
          state     <= B_IDLE;
        end
        B_PROC_RD: state <= B_PROC_WR;
        B_PROC_WR: begin
          if (used_count != '0) begin
            used_count <= used_count - CW'(1);
          end
          if (pi + CW'(1) == dcount[cur_frame]) begin
            dcount[cur_frame] <= '0;
            rsp_valid         <= 1'b1;
            state             <= B_IDLE;
          end else begin
            state <= B_PROC_RD;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Datapath and result fields
  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop) begin
      cur_frame <= head_frame;
      pi        <= '0;
      rsp       <= '0;
      unique case (head.kind)
        K_ALLOC: begin
          if (used_count >= cap_eff) begin
            rsp.status <= ST_FULL;
          end
        end
        K_FREE: begin
          rsp.status     <= q_we ? ST_OK : ST_FULL;
          rsp.slot_index <= SLOT_OUT_W'(head.idx);
        end
        K_PROC:  rsp.status <= ST_OK;
        default: rsp.status <= head.status;
      endcase
    end
    if (state == B_PROC_WR) begin
      pi <= pi + CW'(1);
    end
    if (state == B_ALLOC_RD) begin
      idx_r <= st_rdata;
      off   <= OFF_W'(st_rdata) * OFF_W'(eff_stride(cfg.slot_stride));
    end
    if (state == B_ALLOC_ADD) begin
      rsp.status      <= ST_OK;
      rsp.slot_index  <= SLOT_OUT_W'(idx_r);
      rsp.cpu_address <= cfg.cpu_base + ADDR_W'(off);
      rsp.gpu_address <= cfg.shader_visible ? (cfg.gpu_base + ADDR_W'(off)) : '0;
    end
  end

endmodule

[sim/testbench.sv]
// Testbench for the deferred-free descriptor allocator: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import dfda_pkg::*;

  localparam int SLOTS = DEF_MAX_SLOTS;
  localparam int NFRAMES = DEF_FRAMES;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b1;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  deferred_free_descriptor_allocator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the allocator state and registers
  logic [CAP_W-1:0] sh_capacity;
  logic [STRIDE_W-1:0] sh_stride;
  logic [ADDR_W-1:0] sh_cpu_base, sh_gpu_base;
  logic sh_visible;
  logic [SLOT_OUT_W-1:0] free_slots [SLOTS];
  int unsigned slots_used;
  logic [SLOT_OUT_W-1:0] parked [NFRAMES][SLOTS];
  int unsigned parked_count [NFRAMES];

  rsp_t pending_rsp [$];
  int unsigned live_idx [$];
  int mismatches = 0;
  int max_gap = 11;
  int rx_max_wait = 11;
  bit hold_rx = 1'b0;

  function automatic int unsigned cap_now();
    return (sh_capacity > SLOTS) ? SLOTS : 32'(sh_capacity);
  endfunction

  function automatic logic [ADDR_W-1:0] stride_now();
    return (sh_stride == '0) ? 64'd1 : {55'd0, sh_stride};
  endfunction

  function automatic rsp_t mk_rsp(status_t st, int unsigned idx, logic [ADDR_W-1:0] cpu,
                                  logic [ADDR_W-1:0] gpu);
    rsp_t r;
    r.status = st;
    r.slot_index = idx[SLOT_OUT_W-1:0];
    r.cpu_address = cpu;
    r.gpu_address = gpu;
    return r;
  endfunction

  // Works out the response to one accepted request and advances the shadow state
  function automatic rsp_t predict_response(req_t r);
    logic [ADDR_W-1:0] diff, q, off;
    int unsigned idx, fr;
    fr = 32'(r.frame_slot);
    case (opcode_t'(r.opcode))
      OP_ALLOC: begin
        if (slots_used >= cap_now()) return mk_rsp(ST_FULL, 0, '0, '0);
        idx = 32'(free_slots[slots_used]);
        slots_used++;
        off = idx * stride_now();
        live_idx.insert(live_idx.size(), idx);
        return mk_rsp(ST_OK, idx, sh_cpu_base + off, sh_visible ? sh_gpu_base + off : '0);
      end
      OP_FREE: begin
        if (r.handle_address == '0) return mk_rsp(ST_INVALID, 0, '0, '0);
        if (fr >= NFRAMES || r.handle_address < sh_cpu_base) return mk_rsp(ST_RANGE, 0, '0, '0);
        diff = r.handle_address - sh_cpu_base;
        q = diff / stride_now();
        if (diff % stride_now() != 0 || q >= cap_now()) return mk_rsp(ST_RANGE, 0, '0, '0);
        idx = 32'(q);
        if (parked_count[fr] >= SLOTS) return mk_rsp(ST_FULL, idx, '0, '0);
        parked[fr][parked_count[fr]] = SLOT_OUT_W'(idx);
        parked_count[fr]++;
        return mk_rsp(ST_OK, idx, '0, '0);
      end
      OP_PROCESS: begin
        if (fr >= NFRAMES) return mk_rsp(ST_RANGE, 0, '0, '0);
        // indices met with nothing handed out are dropped
        for (int i = 0; i < parked_count[fr]; i++) begin
          if (slots_used > 0) begin
            slots_used--;
            free_slots[slots_used] = parked[fr][i];
          end
        end
        parked_count[fr] = 0;
        return mk_rsp(ST_OK, 0, '0, '0);
      end
      default: return mk_rsp(ST_RANGE, 0, '0, '0);
    endcase
  endfunction

  function automatic req_t mk_req(opcode_t op, logic [ADDR_W-1:0] addr, int unsigned fr);
    req_t r;
    r.opcode = op;
    r.handle_address = addr;
    r.frame_slot = fr[1:0];
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(int unsigned idx);
    return sh_cpu_base + idx * stride_now();
  endfunction

  // One random request, mostly alloc/free of live slots and drains
  function automatic req_t random_req();
    logic [ADDR_W-1:0] junk;
    int unsigned pick, k, idx;
    junk = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 40 || (pick < 75 && live_idx.size() == 0))
      return mk_req(OP_ALLOC, junk, $urandom_range(0, 3));
    if (pick < 75) begin
      k = $urandom_range(0, live_idx.size() - 1);
      idx = live_idx[k];
      // leave the slot in the list now and then: a double free
      if ($urandom_range(0, 9) != 0) live_idx.delete(k);
      return mk_req(OP_FREE, addr_of(idx), $urandom_range(0, NFRAMES - 1));
    end
    if (pick < 85) return mk_req(OP_PROCESS, junk, $urandom_range(0, NFRAMES - 1));
    if (pick < 88) return mk_req(OP_BAD, junk, $urandom_range(0, 3));
    if (pick < 91) return mk_req(OP_FREE, '0, $urandom_range(0, 3));
    if (pick < 94) return mk_req(OP_FREE, addr_of($urandom_range(0, 1023)), 3);
    if (pick < 97) return mk_req(OP_FREE, addr_of($urandom_range(0, 1023)) + 1, 0);
    return mk_req(OP_FREE, junk, $urandom_range(0, 3));
  endfunction

  // Offer one request; predict on transfer
  task automatic send(req_t r, bit typed, rsp_t want);
    int gap;
    rsp_t got;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    got = predict_response(r);
    pending_rsp.insert(pending_rsp.size(), typed ? want : got);
  endtask

  task automatic idle_req();
    req_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t ix, logic [ADDR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (ix)
      REG_CAPACITY:       sh_capacity = val[CAP_W-1:0];
      REG_SLOT_STRIDE:    sh_stride = val[STRIDE_W-1:0];
      REG_CPU_BASE:       sh_cpu_base = val;
      REG_GPU_BASE:       sh_gpu_base = val;
      REG_SHADER_VISIBLE: sh_visible = val[0];
      default: ;
    endcase
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send(random_req(), 1'b0, '0);
  endtask

  // Directed table
  typedef struct {
    req_t r;
    bit typed;
    rsp_t want;
  } table_row_t;

  table_row_t rows [$];

  task automatic add_row(req_t r, bit typed, rsp_t want);
    table_row_t t;
    t.r = r;
    t.typed = typed;
    t.want = want;
    rows.insert(rows.size(), t);
  endtask

  // Stimulus
  initial begin
    logic [ADDR_W-1:0] same_addr;
    sh_capacity = 11'd1024;
    sh_stride = 9'd32;
    sh_cpu_base = '0;
    sh_gpu_base = '0;
    sh_visible = 1'b0;
    for (int i = 0; i < SLOTS; i++) free_slots[i] = SLOT_OUT_W'(i);
    slots_used = 0;
    for (int f = 0; f < NFRAMES; f++) parked_count[f] = 0;

    add_row(mk_req(OP_ALLOC, '0, 0), 1, mk_rsp(ST_OK, 0, 64'd0, 64'd0));
    add_row(mk_req(OP_ALLOC, '1, 3), 1, mk_rsp(ST_OK, 1, 64'd32, 64'd0));
    add_row(mk_req(OP_FREE, '0, 0), 1, mk_rsp(ST_INVALID, 0, '0, '0));
    add_row(mk_req(OP_FREE, 64'd32, 3), 1, mk_rsp(ST_RANGE, 0, '0, '0));
    add_row(mk_req(OP_FREE, 64'd33, 0), 1, mk_rsp(ST_RANGE, 0, '0, '0));
    add_row(mk_req(OP_FREE, 64'd32768, 0), 1, mk_rsp(ST_RANGE, 0, '0, '0));
    add_row(mk_req(OP_FREE, '1, 2), 1, mk_rsp(ST_RANGE, 0, '0, '0));
    add_row(mk_req(OP_FREE, 64'd32, 1), 1, mk_rsp(ST_OK, 1, '0, '0));
    add_row(mk_req(OP_BAD, '1, 1), 1, mk_rsp(ST_RANGE, 0, '0, '0));
    add_row(mk_req(OP_PROCESS, '0, 3), 1, mk_rsp(ST_RANGE, 0, '0, '0));
    add_row(mk_req(OP_PROCESS, '0, 1), 1, mk_rsp(ST_OK, 0, '0, '0));
    add_row(mk_req(OP_ALLOC, '0, 0), 0, '0);
    add_row(mk_req(OP_PROCESS, '0, 2), 1, mk_rsp(ST_OK, 0, '0, '0));
    add_row(mk_req(OP_FREE, 64'd32736, 0), 0, '0);
    add_row(mk_req(OP_PROCESS, '0, 0), 0, '0);
    add_row(mk_req(OP_ALLOC, '0, 0), 0, '0);
    // park more than is handed out so the drain runs dry
    for (int i = 0; i < 4; i++) add_row(mk_req(OP_FREE, 64'd32, 2), 0, '0);
    add_row(mk_req(OP_PROCESS, '0, 2), 0, '0);
    add_row(mk_req(OP_ALLOC, '0, 0), 0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send(rows[i].r, rows[i].typed, rows[i].want);
    random_run(100);
    idle_req();

    // visible heap, wrapping bases, zero stride; long receiver hold, no sender gaps
    write_reg(REG_SHADER_VISIBLE, 64'd1);
    write_reg(REG_GPU_BASE, '1);
    write_reg(REG_CPU_BASE, 64'hFFFF_FFFF_FFFF_F000);
    write_reg(REG_SLOT_STRIDE, 64'd0);
    max_gap = 0;
    hold_rx = 1'b1;
    random_run(80);
    idle_req();

    // single slot, stride of 256
    max_gap = 11;
    write_reg(REG_CAPACITY, 64'd1);
    write_reg(REG_SLOT_STRIDE, 64'd256);
    write_reg(REG_CPU_BASE, {$urandom, $urandom});
    write_reg(REG_GPU_BASE, {$urandom, $urandom});
    random_run(40);
    idle_req();

    // no slots at all
    write_reg(REG_CAPACITY, 64'd0);
    random_run(20);
    idle_req();

    // capacity above the heap size, receiver never stalls
    rx_max_wait = 0;
    write_reg(REG_CAPACITY, 64'd2047);
    write_reg(REG_SLOT_STRIDE, 64'd255);
    write_reg(REG_SHADER_VISIBLE, 64'd0);
    random_run(100);
    idle_req();

    // park one slot many times over in one frame, then drain it
    rx_max_wait = 11;
    max_gap = 1;
    same_addr = addr_of(5);
    for (int i = 0; i < 40; i++) send(mk_req(OP_FREE, same_addr, 0), 0, '0);
    send(mk_req(OP_PROCESS, '0, 0), 0, '0);
    idle_req();

    // back to the reset settings
    max_gap = 11;
    write_reg(REG_CAPACITY, 64'd1024);
    write_reg(REG_SLOT_STRIDE, 64'd32);
    write_reg(REG_CPU_BASE, 64'd0);
    write_reg(REG_GPU_BASE, 64'd0);
    live_idx.delete();
    random_run(100);
    idle_req();
    repeat (50) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Receiver: random stall before each transfer, one long hold on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = $urandom_range(0, rx_max_wait);
      if (hold_rx) begin
        n = LONG_HOLD;
        hold_rx = 1'b0;
      end
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // Response check against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status || rsp.slot_index !== want.slot_index ||
            rsp.cpu_address !== want.cpu_address || rsp.gpu_address !== want.gpu_address) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, rsp);
        end
      end
    end
  end

  // Watchdog: cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

endmodule

[sim.f]
src/dfda_pkg.sv
src/dfda_fifo.sv
src/dfda_front.sv
src/dfda_back.sv
src/deferred_free_descriptor_allocator.sv
sim/testbench.sv
